[design/llc_pkg.sv]
// Shared constants, codes and saturation helper for the lead-lag compensator.
`timescale 1ns / 1ps
`default_nettype none

package llc_pkg;

  localparam int DATA_W    = 32;
  localparam int LIM_W     = 31;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;
  localparam int WIDE_W    = 50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLE_RATIO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CONSTANT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LIMIT   = 3'd4;

  // Request opcodes.
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Clamp status codes.
  localparam logic [STATUS_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] CLAMP_HIGH = 2'd1;
  localparam logic [STATUS_W-1:0] CLAMP_LOW  = 2'd2;

  localparam logic signed [WIDE_W-1:0] S32_MAX_W = 50'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN_W = -50'sd2147483648;

  // Saturates a wide signed value to the signed 32 bit range.
  function automatic logic [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic [DATA_W-1:0] res;
    if (x > S32_MAX_W) begin
      res = 32'h7FFF_FFFF;
    end else if (x < S32_MIN_W) begin
      res = 32'h8000_0000;
    end else begin
      res = x[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/lead_lag_compensator.sv]
// Lead-lag compensator with a bit-serial multiplier and a bit-serial divider.
//
//   Channel  Ports                                          Moves
//   in       in_valid/in_ready, in_opcode, in_error_in       step or clear request
//   out      out_valid/out_ready, out_control_out,           one result per request
//            out_clamp_status, out_passthrough
//   cfg      cfg_we, cfg_index, cfg_data                     register write, no wait
//
// A step request passes six 32x32 products through one shift-and-add multiplier at one
// bit a cycle and a 64 step restoring divider. A passthrough request ends after the first
// three products, and a clear request goes straight to the output stage.
// One request is in work at a time; in_ready is high only between requests.
// A result waits in the output register while the next request is accepted; the sequencer
// stalls in ST_OUT until that register is free. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none

module lead_lag_compensator
  import llc_pkg::*;
(
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_opcode,
  input  wire  signed [DATA_W-1:0]   in_error_in,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic signed [DATA_W-1:0]   out_control_out,
  output logic        [STATUS_W-1:0] out_clamp_status,
  output logic                       out_passthrough,
  input  wire                        cfg_we,
  input  wire         [CFG_IDX_W-1:0] cfg_index,
  input  wire         [DATA_W-1:0]   cfg_data
);

  localparam int MUL_STEPS = DATA_W;
  localparam int DIV_STEPS = 2 * DATA_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PROD_W    = 2 * DATA_W;
  localparam int RND_W     = PROD_W - FRAC_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_MDONE, ST_KD1, ST_KD0, ST_KN, ST_ABS, ST_DIV, ST_CLAMP,
    ST_SUM, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_AT, MUL_BT, MUL_TB, MUL_PK, MUL_N0, MUL_N1
  } mul_id_t;

  // Configuration registers.
  logic signed [DATA_W-1:0] pole_ratio_r;
  logic signed [DATA_W-1:0] gain_r;
  logic signed [DATA_W-1:0] time_constant_r;
  logic signed [DATA_W-1:0] sample_period_r;
  logic        [LIM_W-1:0]  inner_limit_r;

  // Loop state.
  logic signed [DATA_W-1:0]   prior_inner_r;
  logic        [STATUS_W-1:0] last_clamp_r;

  // Sequencer and datapath registers.
  state_t                   state_r;
  mul_id_t                  mul_id_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [DATA_W-1:0] err_r;
  logic signed [DATA_W-1:0] mul_a_r;
  logic [DATA_W-1:0]        mul_b_r;
  logic [DATA_W:0]          hi_r;
  logic [DATA_W-1:0]        lo_r;
  logic signed [RND_W-1:0]  a1_r;
  logic signed [RND_W-1:0]  b1_r;
  logic signed [RND_W-1:0]  bts_r;
  logic [LIM_W-1:0]         kd1_r;
  logic signed [DATA_W-1:0] kd0_r;
  logic signed [DATA_W-1:0] kn0_r;
  logic signed [DATA_W-1:0] kn1_r;
  logic [PROD_W-1:0]        num_r;
  logic                     neg_r;
  logic [PROD_W-1:0]        div_q_r;
  logic [LIM_W-1:0]         rem_r;
  logic [PROD_W-1:0]        acc_r;
  logic [PROD_W:0]          sum_r;
  logic signed [DATA_W-1:0] inner_r;
  logic [STATUS_W-1:0]      status_r;
  logic [DATA_W-1:0]        res_y_r;
  logic                     pass_r;
  logic                     upd_r;

  // Combinational datapath.
  logic                      mul_last;
  logic [DATA_W:0]           mul_add;
  logic [DATA_W:0]           mul_sum;
  logic [PROD_W-1:0]         prod;
  logic [RND_W-1:0]          prod_rnd;
  logic signed [WIDE_W-1:0]  kd1_w;
  logic signed [WIDE_W-1:0]  kd0_w;
  logic signed [WIDE_W-1:0]  kn0_w;
  logic signed [WIDE_W-1:0]  kn1_w;
  logic                      coef_ok;
  logic [PROD_W-1:0]         err_shift;
  logic [DATA_W-1:0]         div_shift;
  logic [DATA_W:0]           div_trial;
  logic                      div_qbit;
  logic                      over;
  logic [DATA_W-1:0]         inner_mag;
  logic signed [WIDE_W-1:0]  y_rnd;
  logic                      out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    // Signed shift-and-add: the multiplier's sign bit carries negative weight.
    mul_last  = (cnt_r == CNT_W'(MUL_STEPS - 1));
    mul_add   = mul_b_r[0] ? {mul_a_r[DATA_W-1], mul_a_r} : '0;
    mul_sum   = mul_last ? (hi_r - mul_add) : (hi_r + mul_add);
    prod      = {hi_r[DATA_W-1:0], lo_r};
    prod_rnd  = prod[PROD_W-1:FRAC_W] + RND_W'(prod[FRAC_W-1]);

    kd1_w     = WIDE_W'(sample_period_r) + (WIDE_W'(a1_r) <<< 1);
    kd0_w     = WIDE_W'(sample_period_r) - (WIDE_W'(a1_r) <<< 1);
    kn0_w     = WIDE_W'(bts_r) - (WIDE_W'(b1_r) <<< 1);
    kn1_w     = WIDE_W'(bts_r) + (WIDE_W'(b1_r) <<< 1);
    coef_ok   = (sample_period_r > 32'sd0) && (kd1_w > 50'sd0);

    err_shift = {{FRAC_W{err_r[DATA_W-1]}}, err_r, {FRAC_W{1'b0}}};

    // Restoring division of the magnitude, one quotient bit per cycle.
    div_shift = {rem_r, div_q_r[PROD_W-1]};
    div_trial = {1'b0, div_shift} - {2'b00, kd1_r};
    div_qbit  = !div_trial[DATA_W];

    // The quotient magnitude exceeds the limit in either direction alike.
    over      = (|div_q_r[PROD_W-1:LIM_W]) || (div_q_r[LIM_W-1:0] > inner_limit_r);
    inner_mag = over ? {1'b0, inner_limit_r} : {1'b0, div_q_r[LIM_W-1:0]};

    y_rnd     = {sum_r[PROD_W], sum_r[PROD_W:FRAC_W]} + WIDE_W'(sum_r[FRAC_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_ratio_r    <= '0;
      gain_r          <= '0;
      time_constant_r <= '0;
      sample_period_r <= '0;
      inner_limit_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLE_RATIO:    pole_ratio_r    <= cfg_data;
        REG_GAIN:          gain_r          <= cfg_data;
        REG_TIME_CONSTANT: time_constant_r <= cfg_data;
        REG_SAMPLE_PERIOD: sample_period_r <= cfg_data;
        REG_INNER_LIMIT:   inner_limit_r   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      mul_id_r         <= MUL_AT;
      cnt_r            <= '0;
      prior_inner_r    <= '0;
      last_clamp_r     <= CLAMP_NONE;
      out_valid        <= 1'b0;
      out_control_out  <= '0;
      out_clamp_status <= CLAMP_NONE;
      out_passthrough  <= 1'b0;
    end else begin
      // In ST_OUT the output register is reloaded below instead.
      if (out_valid && out_ready && (state_r != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_opcode == OP_CLEAR) begin
              res_y_r  <= '0;
              status_r <= CLAMP_NONE;
              pass_r   <= 1'b0;
              inner_r  <= '0;
              upd_r    <= 1'b1;
              state_r  <= ST_OUT;
            end else begin
              err_r    <= in_error_in;
              mul_a_r  <= pole_ratio_r;
              mul_b_r  <= time_constant_r;
              hi_r     <= '0;
              cnt_r    <= '0;
              mul_id_r <= MUL_AT;
              state_r  <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          hi_r    <= {mul_sum[DATA_W], mul_sum[DATA_W:1]};
          lo_r    <= {mul_sum[0], lo_r[DATA_W-1:1]};
          mul_b_r <= {1'b0, mul_b_r[DATA_W-1:1]};
          cnt_r   <= cnt_r + 1'b1;
          if (mul_last) begin
            state_r <= ST_MDONE;
          end
        end
        ST_MDONE: begin
          hi_r  <= '0;
          cnt_r <= '0;
          unique case (mul_id_r)
            MUL_AT: begin
              a1_r     <= prod_rnd;
              mul_a_r  <= gain_r;
              mul_b_r  <= time_constant_r;
              mul_id_r <= MUL_BT;
              state_r  <= ST_MUL;
            end
            MUL_BT: begin
              b1_r     <= prod_rnd;
              mul_a_r  <= sample_period_r;
              mul_b_r  <= gain_r;
              mul_id_r <= MUL_TB;
              state_r  <= ST_MUL;
            end
            MUL_TB: begin
              bts_r   <= prod_rnd;
              state_r <= ST_KD1;
            end
            MUL_PK: begin
              num_r   <= err_shift - prod;
              state_r <= ST_ABS;
            end
            MUL_N0: begin
              acc_r    <= prod;
              mul_a_r  <= kn1_r;
              mul_b_r  <= inner_r;
              mul_id_r <= MUL_N1;
              state_r  <= ST_MUL;
            end
            default: begin
              sum_r   <= {acc_r[PROD_W-1], acc_r} + {prod[PROD_W-1], prod};
              state_r <= ST_SUM;
            end
          endcase
        end
        ST_KD1: begin
          if (coef_ok) begin
            kd1_r   <= LIM_W'(sat32(kd1_w));
            state_r <= ST_KD0;
          end else begin
            // Invalid coefficients: hand the error back and leave the state alone.
            res_y_r  <= err_r;
            status_r <= last_clamp_r;
            pass_r   <= 1'b1;
            upd_r    <= 1'b0;
            state_r  <= ST_OUT;
          end
        end
        ST_KD0: begin
          kd0_r   <= sat32(kd0_w);
          state_r <= ST_KN;
        end
        ST_KN: begin
          kn0_r    <= sat32(kn0_w);
          kn1_r    <= sat32(kn1_w);
          mul_a_r  <= kd0_r;
          mul_b_r  <= prior_inner_r;
          hi_r     <= '0;
          cnt_r    <= '0;
          mul_id_r <= MUL_PK;
          state_r  <= ST_MUL;
        end
        ST_ABS: begin
          neg_r   <= num_r[PROD_W-1];
          div_q_r <= num_r[PROD_W-1] ? (PROD_W'(0) - num_r) : num_r;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r   <= div_qbit ? div_trial[LIM_W-1:0] : div_shift[LIM_W-1:0];
          div_q_r <= {div_q_r[PROD_W-2:0], div_qbit};
          cnt_r   <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          inner_r  <= neg_r ? (DATA_W'(0) - inner_mag) : inner_mag;
          if (!over) begin
            status_r <= CLAMP_NONE;
          end else if (neg_r) begin
            status_r <= CLAMP_LOW;
          end else begin
            status_r <= CLAMP_HIGH;
          end
          pass_r   <= 1'b0;
          upd_r    <= 1'b1;
          mul_a_r  <= kn0_r;
          mul_b_r  <= prior_inner_r;
          hi_r     <= '0;
          cnt_r    <= '0;
          mul_id_r <= MUL_N0;
          state_r  <= ST_MUL;
        end
        ST_SUM: begin
          res_y_r <= sat32(y_rnd);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            out_control_out  <= res_y_r;
            out_clamp_status <= status_r;
            out_passthrough  <= pass_r;
            if (upd_r) begin
              prior_inner_r <= inner_r;
              last_clamp_r  <= status_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
